// ===== rtl/core/hcp_pkg.sv =====
// Shared types and constants for the Huffman code packer.
package hcp_pkg;

  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 4;
  localparam int TOTAL_W   = 48;

  localparam int DEF_SYMBOL_COUNT = 256;
  localparam int DEF_MAX_CODE_LEN = 32;

  localparam logic [CNT_W-1:0]   FULL_BYTE_CNT = CNT_W'(BYTE_W);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
    tbl_entry_t       data;
  } tbl_wr_t;

endpackage

// ===== rtl/core/hcp_code_table.sv =====
// Code table memory: one write port, one registered read port, per-entry valid bits.
module hcp_code_table #(
  parameter int SYMBOL_COUNT = hcp_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hcp_pkg::tbl_wr_t                wr,
  input  logic                            rd_en,
  input  logic [hcp_pkg::SYM_W-1:0]       rd_addr,
  output hcp_pkg::tbl_entry_t             rd_data
);
  import hcp_pkg::*;

  localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  tbl_entry_t              mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_r;
  tbl_entry_t              rd_q_r;
  logic                    rd_vld_r;
  logic [AW-1:0]           widx;
  logic [AW-1:0]           ridx;

  assign widx = wr.addr[AW-1:0];
  assign ridx = rd_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[widx] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[widx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[ridx];
      end
    end
  end

  // Unwritten entries read as absent symbols.
  assign rd_data.len  = rd_vld_r ? rd_q_r.len  : '0;
  assign rd_data.code = rd_vld_r ? rd_q_r.code : '0;

endmodule

// ===== rtl/core/huffman_code_packer_core.sv =====
// Huffman code packer top level: table lookup, bit packing and byte output.
//
//   Channel  Handshake             Payload
//   -------  --------------------  -----------------------------------------------
//   input    in_valid / in_ready   in_func, in_symbol, in_code_bits, in_code_length
//   result   out_valid / out_ready out_byte, out_bit_count, out_total_bits, out_last
//
// A request is taken every cycle while the packer keeps up. A request flows through
// the registered table read into the packer; an encode that completes k bytes
// (k <= 4) holds the packer until the single output register has taken each byte,
// one byte per cycle while out_ready allows. Reset clears the table valid bits, the
// accumulator, the bit total and all handshake state; no clearing pass is needed.
// out_ready low stalls the packer, then the table stage, then in_ready.
module huffman_code_packer_core #(
  parameter int SYMBOL_COUNT = hcp_pkg::DEF_SYMBOL_COUNT,
  parameter int MAX_CODE_LEN = hcp_pkg::DEF_MAX_CODE_LEN
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [hcp_pkg::SYM_W-1:0]     in_symbol,
  input  logic [hcp_pkg::CODE_W-1:0]    in_code_bits,
  input  logic [hcp_pkg::LEN_W-1:0]     in_code_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hcp_pkg::BYTE_W-1:0]    out_byte,
  output logic [hcp_pkg::CNT_W-1:0]     out_bit_count,
  output logic [hcp_pkg::TOTAL_W-1:0]   out_total_bits,
  output logic                          out_last
);
  import hcp_pkg::*;

  // Longest code the table keeps, and derived packing widths.
  localparam int LEN_LIMIT_I = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_I);
  localparam int ACC_W  = BYTE_W - 1;          // pending bits never reach a full byte
  localparam int VEC_W  = ACC_W + CODE_W;      // pending bits plus one code
  localparam int ALN_W  = VEC_W + 1;           // left-aligned window, whole bytes
  localparam int NB     = CODE_W / BYTE_W;     // bytes one request can complete
  localparam int BUF_W  = NB * BYTE_W;
  localparam int LEFT_W = $clog2(NB + 1);
  localparam int PC_W   = $clog2(ACC_W + 1);

  // ---------------------------------------------------------------- input side
  logic       in_fire;
  logic       in_hit;
  logic [LEN_W-1:0]  load_len;
  logic [CODE_W:0]   load_mask;
  tbl_wr_t    tbl_wr;
  tbl_entry_t tbl_rd;

  assign in_fire = in_valid && in_ready;
  assign in_hit  = {1'b0, in_symbol} < (SYM_W + 1)'(SYMBOL_COUNT);

  // Clamp overlong lengths and drop code bits above the length.
  always_comb begin
    load_len  = (in_code_length > LEN_LIMIT) ? LEN_LIMIT : in_code_length;
    load_mask = ((CODE_W + 1)'(1) << load_len) - (CODE_W + 1)'(1);
  end

  always_comb begin
    tbl_wr.en        = in_fire && in_hit && (in_func == FUNC_LOAD);
    tbl_wr.addr      = in_symbol;
    tbl_wr.data.len  = load_len;
    tbl_wr.data.code = in_code_bits & load_mask[CODE_W-1:0];
  end

  // Writes land at the accepting edge, so a later read always sees them.
  hcp_code_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_en   (in_fire),
    .rd_addr (in_symbol),
    .rd_data (tbl_rd)
  );

  // ---------------------------------------------------------------- lookup stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_func_r;
  logic       s1_hit_r;
  logic       s1_adv;

  // ---------------------------------------------------------------- packer state
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [PC_W-1:0]    cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [BUF_W-1:0]   pk_buf_r, pk_buf_nxt;
  logic [LEFT_W-1:0]  pk_left_r, pk_left_nxt;
  logic               pk_flush_r, pk_flush_nxt;
  logic [PC_W-1:0]    pk_fcnt_r, pk_fcnt_nxt;
  logic               pk_free;

  // ---------------------------------------------------------------- output register
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic [TOTAL_W-1:0]   out_total_r;
  logic                 out_last_r;
  logic                 out_load;

  // Move one byte whenever one is pending and the output register is free or being drained.
  assign out_load = (pk_left_r != '0) && (!out_valid_r || out_ready);
  assign pk_free  = (pk_left_r == '0) ||
                    ((pk_left_r == LEFT_W'(1)) && out_load);
  assign s1_adv   = s1_valid_r && pk_free;
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------- packing
  logic                is_enc;
  logic [LEN_W-1:0]    len_eff;
  logic [CODE_W-1:0]   code_eff;
  logic [VEC_W-1:0]    vec;
  logic [LEN_W-1:0]    nbits;
  logic [ALN_W-1:0]    aligned;
  logic [TOTAL_W:0]    total_sum;
  logic [ACC_W-1:0]    rem_mask;

  always_comb begin
    is_enc    = (s1_func_r == FUNC_ENCODE) && s1_hit_r;
    len_eff   = is_enc ? tbl_rd.len  : '0;
    code_eff  = is_enc ? tbl_rd.code : '0;
    // Append the code below the pending bits.
    vec       = (VEC_W'(acc_r) << len_eff) | VEC_W'(code_eff);
    nbits     = LEN_W'(cnt_r) + len_eff;
    // Left-align so completed bytes sit at the top of the window.
    aligned   = ALN_W'(vec) << (LEN_W'(ALN_W) - nbits);
    rem_mask  = ACC_W'((ACC_W + 1)'(1) << nbits[PC_W-1:0]) - ACC_W'(1);
    total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(len_eff);
  end

  always_comb begin
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    total_nxt    = total_r;
    pk_buf_nxt   = pk_buf_r;
    pk_left_nxt  = pk_left_r;
    pk_flush_nxt = pk_flush_r;
    pk_fcnt_nxt  = pk_fcnt_r;
    if (out_load) begin
      pk_buf_nxt  = pk_buf_r << BYTE_W;
      pk_left_nxt = pk_left_r - LEFT_W'(1);
    end
    if (s1_adv) begin
      case (s1_func_r)
        FUNC_ENCODE: begin
          pk_buf_nxt   = aligned[ALN_W-1 -: BUF_W];
          pk_left_nxt  = LEFT_W'(nbits / BYTE_W);
          pk_flush_nxt = 1'b0;
          acc_nxt      = vec[ACC_W-1:0] & rem_mask;
          cnt_nxt      = nbits[PC_W-1:0];
          total_nxt    = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        end
        FUNC_FLUSH: begin
          // Hand the pending bits right-aligned, then clear them.
          pk_buf_nxt   = {1'b0, acc_r, (BUF_W - BYTE_W)'(0)};
          pk_left_nxt  = LEFT_W'(1);
          pk_flush_nxt = 1'b1;
          pk_fcnt_nxt  = cnt_r;
          acc_nxt      = '0;
          cnt_nxt      = '0;
        end
        default: begin
          // Loads and unused codes leave the packer untouched.
          pk_left_nxt  = out_load ? pk_left_r - LEFT_W'(1) : pk_left_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      pk_left_r   <= '0;
      pk_flush_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      pk_left_r   <= pk_left_nxt;
      pk_flush_r  <= pk_flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_func;
      s1_hit_r  <= in_hit;
    end
    pk_buf_r  <= pk_buf_nxt;
    pk_fcnt_r <= pk_fcnt_nxt;
    if (out_load) begin
      out_byte_r  <= pk_buf_r[BUF_W-1 -: BYTE_W];
      out_cnt_r   <= pk_flush_r ? CNT_W'(pk_fcnt_r) : FULL_BYTE_CNT;
      // No encode can slip in before the flush byte leaves, so the total is current.
      out_total_r <= pk_flush_r ? total_r : '0;
      out_last_r  <= pk_flush_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_bit_count  = out_cnt_r;
  assign out_total_bits = out_total_r;
  assign out_last       = out_last_r;

endmodule
